>>> hw/rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, types and round functions for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  // Queue entry between the front end and the hashing engine.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } md5_item_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PAD,
    ST_LEN,
    ST_HASH,
    ST_ADD,
    ST_EMIT
  } md5_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] sel);
    logic [4:0] s;
    begin
      case (sel)
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] w;
    begin
      case (i[5:4])
        2'd0: w = i[3:0];
        2'd1: w = 4'(5 * i[3:0] + 1);
        2'd2: w = 4'(3 * i[3:0] + 5);
        default: w = 4'(7 * i[3:0]);
      endcase
      return w;
    end
  endfunction

endpackage

>>> hw/rtl/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// Accepts input beats into a four-entry queue that the engine drains.
// ----------------------------------------------------------------------------
module md5_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  md5_pkg::md5_item_t  in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output md5_pkg::md5_item_t  q_item
);
  import md5_pkg::*;

  md5_item_t  slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 3'd4);
  assign q_valid  = (count != 3'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd4) |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd0) |-> !pop) else $error("pop from empty queue");

endmodule

>>> hw/rtl/md5_engine.sv
// ----------------------------------------------------------------------------
// md5_engine
// Gathers bytes into the block store, pads, runs one round per cycle and
// emits the digest words.
// ----------------------------------------------------------------------------
module md5_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  md5_pkg::md5_item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_word,
  output logic [1:0]          out_index,
  output logic                out_last
);
  import md5_pkg::*;

  md5_state_t  state, state_next;
  logic [31:0] block [16];
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [63:0] bit_total;
  logic [63:0] len;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [2:0]  len_cnt;
  logic        final_pending;
  logic [1:0]  emit_idx;
  md5_state_t  after_hash;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  sh;

  always_comb begin
    case (rnd[5:4])
      2'd0: f_val = (b & c) | (~b & d);
      2'd1: f_val = (b & d) | (c & ~d);
      2'd2: f_val = b ^ c ^ d;
      default: f_val = c ^ (b | ~d);
    endcase
    sum = a + f_val + round_k(rnd) + block[msg_index(rnd)];
    sh  = rot_amt({rnd[5:4], rnd[1:0]});
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign q_ready   = (state == ST_TAKE);
  assign out_valid = (state == ST_EMIT);
  assign out_word  = chain[emit_idx];
  assign out_index = emit_idx;
  assign out_last  = (emit_idx == 2'd3);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = q_item.data;
    case (state)
      ST_TAKE: wr_en = q_valid && q_item.valid;
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = final_pending ? 8'h00 : PAD_BYTE;
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = len[8*len_cnt +: 8];
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_TAKE: begin
        if (q_valid) begin
          if (q_item.valid && pos == 6'd63) state_next = ST_HASH;
          else if (q_item.eom) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos == 6'd63) state_next = ST_HASH;
        else if (pos + 6'd1 == LEN_POS) state_next = ST_LEN;
      end
      ST_LEN:  if (len_cnt == 3'd7) state_next = ST_HASH;
      ST_HASH: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD:  state_next = after_hash;
      ST_EMIT: if (out_ready && emit_idx == 2'd3) state_next = ST_TAKE;
      default: state_next = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      block[pos[5:2]][8*pos[1:0] +: 8] <= wr_byte;
    end
    if (state == ST_HASH) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot;
    end else begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end
    if (rst) begin
      state         <= ST_TAKE;
      chain[0]      <= INIT_A;
      chain[1]      <= INIT_B;
      chain[2]      <= INIT_C;
      chain[3]      <= INIT_D;
      bit_total     <= '0;
      len           <= '0;
      pos           <= '0;
      rnd           <= '0;
      len_cnt       <= '0;
      final_pending <= 1'b0;
      emit_idx      <= '0;
      after_hash    <= ST_TAKE;
    end else begin
      state <= state_next;
      if (wr_en) pos <= pos + 6'd1;
      case (state)
        ST_TAKE: begin
          if (q_valid) begin
            if (q_item.valid) bit_total <= bit_total + 64'd8;
            len <= q_item.valid ? bit_total + 64'd8 : bit_total;
            // The engine returns here after a full block unless the marker
            // rode on the filling byte, in which case padding follows.
            after_hash <= q_item.eom ? ST_PAD : ST_TAKE;
            final_pending <= 1'b0;
          end
        end
        ST_PAD: begin
          final_pending <= 1'b1;
          after_hash    <= ST_PAD;
          len_cnt       <= '0;
        end
        ST_LEN: begin
          len_cnt    <= len_cnt + 3'd1;
          after_hash <= ST_EMIT;
        end
        ST_HASH: rnd <= rnd + 6'd1;
        ST_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              chain[0]  <= INIT_A;
              chain[1]  <= INIT_B;
              chain[2]  <= INIT_C;
              chain[3]  <= INIT_D;
              bit_total <= '0;
              pos       <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(emit_idx)))
    else $error("digest word moved while stalled");
  a_hash_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HASH && rnd == 6'd63) |=> state == ST_ADD)
    else $error("compression did not end after 64 rounds");
  a_pos_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HASH) |-> pos == 6'd0)
    else $error("block hashed before it was full");

endmodule

>>> hw/rtl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 hash of a byte stream, digest returned as four 32-bit words.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one optional message byte and an optional
// end-of-message flag. s_tdata[7:0] is the byte, s_tuser[0] says the byte is
// present and s_tlast ends the message, so an empty message is a beat with
// s_tuser low and s_tlast high. A beat with neither does nothing.
// Beats enter a four-entry queue; the hashing engine takes one byte per
// cycle while it is not compressing, and every 64th byte starts a
// compression (one round per cycle through a single round unit) followed
// by a step that folds the result into the chaining words.
// At the end of a message the engine writes padding and the length, one
// byte per cycle, compresses once or twice, then presents words A to D on
// m_tdata with the index on m_tuser and m_tlast on word D. A stalled
// receiver holds the current word; the queue keeps taking beats until full.
// Reset is synchronous and returns the chaining words to the MD5 initial
// values, clears the bit count and empties the queue.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [1:0]  m_tuser,   // word_index
  output logic        m_tlast    // last_word
);
  import md5_pkg::*;

  md5_item_t in_item;
  md5_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  assign in_item.data  = s_tdata;
  assign in_item.valid = s_tuser;
  assign in_item.eom   = s_tlast;

  md5_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  md5_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_index (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MD5 digest block: byte streams go in as beats,
// a behavioral MD5 in the bench predicts the four digest words of every
// message, and each output beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import md5_pkg::*;

  // One input beat as the bench sees it.
  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_beat_t;

  // One digest word as the block should present it.
  typedef struct {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // Set by the monitor when the beat on the input was taken at the last edge.
  logic        beat_taken = 1'b0;

  msg_beat_t    pending_beats[$];
  digest_beat_t digest_queue[$];

  // Percentages of idle cycles on either side, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Bench copy of the hashing state.
  logic [31:0] hash_state[4];
  logic [7:0]  msg_block[64];
  logic [63:0] msg_bits;

  md5_message_digest dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Constant tables are written out here so that the prediction does not
  // lean on the functions of the package.
  localparam logic [31:0] SINE_K[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFTS[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                6, 10, 15, 21};

  task automatic start_digest();
    hash_state[0] = INIT_A;
    hash_state[1] = INIT_B;
    hash_state[2] = INIT_C;
    hash_state[3] = INIT_D;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, j, sh;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      g = i / 16;
      case (g)
        0: begin f = (b & c) | (~b & d); j = i % 16; end
        1: begin f = (b & d) | (c & ~d); j = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          j = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); j = (7 * i) % 16; end
      endcase
      sh = SHIFTS[g * 4 + i % 4];
      sum = a + f + SINE_K[i] + w[j];
      t = d; d = c; c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
  endtask

  // Stores one byte at the current fill position; a full block compresses.
  task automatic place_byte(inout int pos, input logic [7:0] v);
    msg_block[pos] = v;
    pos = (pos + 1) % 64;
    if (pos == 0) compress_block();
  endtask

  // Advances the bench state by one beat and queues any digest it finishes.
  task automatic predict_digest(input msg_beat_t bt);
    int pos;
    logic [63:0] len;
    if (bt.byte_valid) begin
      pos = int'(msg_bits[8:3]);
      place_byte(pos, bt.data_byte);
      msg_bits += 64'd8;
    end
    if (bt.end_of_message) begin
      len = msg_bits;
      pos = int'(len[8:3]);
      place_byte(pos, PAD_BYTE);
      while (pos != 56) place_byte(pos, 8'h00);
      for (int k = 0; k < 8; k++) place_byte(pos, len[8*k +: 8]);
      for (int k = 0; k < 4; k++)
        digest_queue.push_back('{hash_state[k], 2'(k), k == 3});
      start_digest();
    end
  endtask

  task automatic push_beat(input logic [7:0] db, input logic bv, input logic em);
    pending_beats.push_back('{db, bv, em});
  endtask

  // A message of n random bytes, with the marker either on the last byte or
  // on a beat of its own. Empty beats are sprinkled in as noise.
  task automatic push_message(input int n);
    logic split;
    split = 1'($urandom_range(1, 0));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, (i == n - 1) && !split);
    end
    if (split || n == 0) push_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Driver: beats change on the falling edge; a beat stays on the bus until
  // it has been taken, and the next one comes from the head of the queue.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || beat_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_beats[0].data_byte;
          s_tuser  <= pending_beats[0].byte_valid;
          s_tlast  <= pending_beats[0].end_of_message;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Monitor: accepts both handshakes on the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    beat_taken  <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_digest(pending_beats[0]);
        void'(pending_beats.pop_front());
      end
      if (m_tvalid && m_tready) begin
        if (digest_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest beat: word %h index %0d last %b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          if (m_tdata !== digest_queue[0].digest_word ||
              m_tuser !== digest_queue[0].word_index ||
              m_tlast !== digest_queue[0].last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       digest_queue[0].digest_word, digest_queue[0].word_index,
                       digest_queue[0].last_word, m_tdata, m_tuser, m_tlast);
          end
          void'(digest_queue.pop_front());
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0 || digest_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] edge_bytes[4];
    int sent;
    edge_bytes = '{8'h00, 8'hff, 8'h55, 8'haa};
    start_digest();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty messages, a beat that does nothing, single bytes 00, ff, 55
    // and aa with the marker on the byte, and two bytes with the marker on its own beat.
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b1);
    foreach (edge_bytes[i]) push_beat(edge_bytes[i], 1'b1, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'h5a, 1'b0, 1'b1);
    wait_drained();

    // Random messages; lengths around 55, 56 and 64 bytes decide whether the
    // padding needs a second block, so they get extra weight.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      sent = 0;
      while (sent < 30) begin
        int n;
        case ($urandom_range(3, 0))
          0: n = $urandom_range(3, 0);
          1: n = $urandom_range(57, 54);
          2: n = $urandom_range(65, 63);
          default: n = $urandom_range(20, 4);
        endcase
        push_message(n);
        sent += n + 1;
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
